// ===== src/vram_bank_page_mapper_defines.svh =====
// Assertion macros for the VRAM bank page mapper.
// Each macro expects the signals clk and rst_n in the scope where it is used.
`ifndef VRAM_BANK_PAGE_MAPPER_DEFINES_SVH
`define VRAM_BANK_PAGE_MAPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VBPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VBPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/vbpm_pkg.sv =====
// Package for the VRAM bank page mapper: bank constants, region and target
// codes, shared types and the per-bank decode function. No dependencies.
`default_nettype none

package vbpm_pkg;

  localparam int NBANKS = 9;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Region codes seen on the lookup side.
  localparam logic [2:0] RG_LCDC = 3'd0;
  localparam logic [2:0] RG_BGA  = 3'd1;
  localparam logic [2:0] RG_OBJA = 3'd2;
  localparam logic [2:0] RG_BGB  = 3'd3;
  localparam logic [2:0] RG_OBJB = 3'd4;
  localparam logic [2:0] RG_ARM7 = 3'd5;
  localparam logic [2:0] RG_TEXD = 3'd6;
  localparam logic [2:0] RG_TEXP = 3'd7;

  // Target field codes of a control byte; the meaning of 1..4 depends on the bank.
  localparam logic [2:0] MST_LCDC = 3'd0;
  localparam logic [2:0] MST_T1   = 3'd1;
  localparam logic [2:0] MST_T2   = 3'd2;
  localparam logic [2:0] MST_T3   = 3'd3;
  localparam logic [2:0] MST_T4   = 3'd4;

  localparam logic [3:0] BANK_A = 4'd0;
  localparam logic [3:0] BANK_B = 4'd1;
  localparam logic [3:0] BANK_C = 4'd2;
  localparam logic [3:0] BANK_D = 4'd3;
  localparam logic [3:0] BANK_E = 4'd4;
  localparam logic [3:0] BANK_F = 4'd5;
  localparam logic [3:0] BANK_G = 4'd6;
  localparam logic [3:0] BANK_H = 4'd7;
  localparam logic [3:0] BANK_I = 4'd8;

  localparam logic [7:0] WRITE_MASK [NBANKS] =
    '{8'h9b, 8'h9b, 8'h9f, 8'h9f, 8'h87, 8'h9f, 8'h9f, 8'h83, 8'h83};
  localparam logic [7:0] BANK_SIZE [NBANKS] =
    '{8'd32, 8'd32, 8'd32, 8'd32, 8'd16, 8'd4, 8'd4, 8'd8, 8'd4};
  localparam logic [7:0] LCDC_BASE [NBANKS] =
    '{8'h00, 8'h20, 8'h40, 8'h60, 8'h80, 8'h90, 8'h94, 8'h98, 8'hA0};

  typedef logic [NBANKS-1:0][7:0] ctrl_arr_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] region;
    logic [7:0] base;
  } map_t;

  typedef struct packed {
    logic [NBANKS-1:0] hits;
    logic [4:0]        page;
  } lookup_t;

  // Region and base page that bank n covers with control byte c.
  function automatic map_t bank_map(input logic [3:0] n, input logic [7:0] c);
    map_t       m;
    logic [2:0] mst;
    logic [1:0] ofs;
    logic [7:0] small_base;
    logic [7:0] big_base;
    logic [7:0] half_base;
    m          = '0;
    mst        = c[2:0];
    ofs        = c[4:3];
    small_base = {3'b000, ofs[1], 1'b0, ofs[0], 2'b00};
    big_base   = {1'b0, ofs, 5'b00000};
    half_base  = {2'b00, ofs[0], 5'b00000};
    if (c[7]) begin
      if (mst == MST_LCDC) begin
        m = '{ok: 1'b1, region: RG_LCDC, base: LCDC_BASE[n]};
      end else begin
        unique case (n)
          BANK_A, BANK_B: begin
            if (mst == MST_T1)      m = '{ok: 1'b1, region: RG_BGA,  base: big_base};
            else if (mst == MST_T2) m = '{ok: 1'b1, region: RG_OBJA, base: half_base};
            else if (mst == MST_T3) m = '{ok: 1'b1, region: RG_TEXD, base: big_base};
          end
          BANK_C, BANK_D: begin
            if (mst == MST_T1)      m = '{ok: 1'b1, region: RG_BGA,  base: big_base};
            else if (mst == MST_T2) m = '{ok: 1'b1, region: RG_ARM7, base: half_base};
            else if (mst == MST_T3) m = '{ok: 1'b1, region: RG_TEXD, base: big_base};
            else if (mst == MST_T4) begin
              m = '{ok: 1'b1, region: (n == BANK_C) ? RG_BGB : RG_OBJB, base: 8'd0};
            end
          end
          BANK_E: begin
            if (mst == MST_T1)      m = '{ok: 1'b1, region: RG_BGA,  base: 8'd0};
            else if (mst == MST_T2) m = '{ok: 1'b1, region: RG_OBJA, base: 8'd0};
            else if (mst == MST_T3) m = '{ok: 1'b1, region: RG_TEXP, base: 8'd0};
          end
          BANK_F, BANK_G: begin
            if (mst == MST_T1)      m = '{ok: 1'b1, region: RG_BGA,  base: small_base};
            else if (mst == MST_T2) m = '{ok: 1'b1, region: RG_OBJA, base: small_base};
            else if (mst == MST_T3) m = '{ok: 1'b1, region: RG_TEXP, base: small_base};
          end
          BANK_H: begin
            if (mst == MST_T1) m = '{ok: 1'b1, region: RG_BGB, base: 8'd0};
          end
          BANK_I: begin
            if (mst == MST_T1)      m = '{ok: 1'b1, region: RG_BGB,  base: 8'd8};
            else if (mst == MST_T2) m = '{ok: 1'b1, region: RG_OBJB, base: 8'd0};
          end
          default: m = '0;
        endcase
      end
    end
    return m;
  endfunction

  // Status bits: bit 0 when bank C is enabled on ARM7, bit 1 for bank D.
  function automatic logic [1:0] arm7_of(input ctrl_arr_t ctrl);
    logic [1:0] s;
    s[0] = ctrl[BANK_C][7] && (ctrl[BANK_C][2:0] == MST_T2);
    s[1] = ctrl[BANK_D][7] && (ctrl[BANK_D][2:0] == MST_T2);
    return s;
  endfunction

  // True when no bank holds a bit outside its writable mask.
  function automatic logic ctrl_in_mask(input ctrl_arr_t ctrl);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NBANKS; i++) begin
      if ((ctrl[i] & ~WRITE_MASK[i]) != 8'd0) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

// ===== src/vbpm_lookup.sv =====
// Page lookup across all nine banks: decodes each control register, compares
// the page against each mapping and picks the lowest hit. Uses vbpm_pkg.
`default_nettype none

module vbpm_lookup (
  input  vbpm_pkg::ctrl_arr_t bank_control,
  input  logic [2:0]          region_select,
  input  logic [7:0]          page_number,
  output vbpm_pkg::lookup_t   result
);
  import vbpm_pkg::*;

  logic [NBANKS-1:0] hit;
  logic [4:0]        offs [NBANKS];

  always_comb begin
    map_t       m;
    logic [8:0] lim;
    logic [7:0] diff;
    for (int i = 0; i < NBANKS; i++) begin
      m       = bank_map(4'(i), bank_control[i]);
      lim     = {1'b0, m.base} + {1'b0, BANK_SIZE[i]};
      diff    = page_number - m.base;
      hit[i]  = m.ok && (m.region == region_select) && (page_number >= m.base) &&
                ({1'b0, page_number} < lim);
      offs[i] = diff[4:0];
    end
  end

  // Scan from the top so the lowest hitting bank wins.
  always_comb begin
    result.hits = hit;
    result.page = 5'd0;
    for (int i = NBANKS - 1; i >= 0; i--) begin
      if (hit[i]) result.page = offs[i];
    end
  end

endmodule

`default_nettype wire

// ===== src/vram_bank_page_mapper.sv =====
// Top level of the VRAM bank page mapper: input register, bank control state,
// lookup and result register. Uses vbpm_pkg, vbpm_lookup and the assertion header.
`default_nettype none
`include "vram_bank_page_mapper_defines.svh"

// The mapper takes one item per clock cycle unless the result side stalls, and
// registers each item in the input register and its result in the result
// register. Between them a single pass of decode logic either stores a masked
// control byte or compares the page against all nine bank mappings. A lookup
// sees every write transferred before it. Every item, write or lookup, yields
// one result; a write returns zero hits and page and the status after the write.
// When the result side stalls, the input register holds one more item and the
// input stalls after that.
module vram_bank_page_mapper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_operation,
  input  logic [3:0] in_bank_select,
  input  logic [7:0] in_control_byte,
  input  logic [2:0] in_region_select,
  input  logic [7:0] in_page_number,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] out_bank_hits,
  output logic [4:0] out_bank_page,
  output logic [1:0] out_status_bits
);
  import vbpm_pkg::*;

  logic       s1_valid_r;
  logic       s1_op_r;
  logic [3:0] s1_bank_r;
  logic [7:0] s1_byte_r;
  logic [2:0] s1_region_r;
  logic [7:0] s1_page_r;

  ctrl_arr_t  bank_control_r, bank_control_nxt;
  logic [1:0] arm7_status_r, arm7_status_nxt;

  logic       out_valid_r;
  logic [8:0] out_bank_hits_r;
  logic [4:0] out_bank_page_r;
  logic [1:0] out_status_r;

  logic       s1_move;
  lookup_t    lk;

  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;

  vbpm_lookup u_lookup (
    .bank_control  (bank_control_r),
    .region_select (s1_region_r),
    .page_number   (s1_page_r),
    .result        (lk)
  );

  always_comb begin
    bank_control_nxt = bank_control_r;
    if (s1_move && (s1_op_r == OP_WRITE) && (s1_bank_r < 4'(NBANKS))) begin
      bank_control_nxt[s1_bank_r] = s1_byte_r & WRITE_MASK[s1_bank_r];
    end
    arm7_status_nxt = arm7_of(bank_control_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      bank_control_r <= '0;
      arm7_status_r  <= 2'b00;
    end else begin
      if (!in_stall) s1_valid_r <= in_valid;
      if (s1_move) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      bank_control_r <= bank_control_nxt;
      arm7_status_r  <= arm7_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r     <= in_operation;
      s1_bank_r   <= in_bank_select;
      s1_byte_r   <= in_control_byte;
      s1_region_r <= in_region_select;
      s1_page_r   <= in_page_number;
    end
    if (s1_move) begin
      out_bank_hits_r <= (s1_op_r == OP_LOOKUP) ? lk.hits : 9'd0;
      out_bank_page_r <= (s1_op_r == OP_LOOKUP) ? lk.page : 5'd0;
      out_status_r    <= arm7_status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bank_hits   = out_bank_hits_r;
  assign out_bank_page   = out_bank_page_r;
  assign out_status_bits = out_status_r;

  `VBPM_ASSERT_IMP(a_status_tracks_ctrl, 1'b1, arm7_status_r == arm7_of(bank_control_r), "status bits disagree with bank C/D control")
  `VBPM_ASSERT_IMP(a_ctrl_masked, 1'b1, ctrl_in_mask(bank_control_r), "bank control holds bits outside its write mask")
  `VBPM_ASSERT_IMP(a_no_hit_zero_page, out_valid_r && (out_bank_hits_r == 9'd0), out_bank_page_r == 5'd0, "bank page nonzero without a hit")
  `VBPM_ASSERT_NEXT(a_move_fills_output, s1_move, out_valid_r, "result register empty after a transfer from the input register")

endmodule

`default_nettype wire
